FILE: hdl/tcmv_pkg.sv
// Shared types and constants of the temporal color majority vote block.
`default_nettype none

package tcmv_pkg;

    localparam int HISTORY_DEPTH_DEF = 64;
    localparam int MAX_PER_FRAME_DEF = 2;
    localparam int FIFO_DEPTH        = 2;

    localparam logic [6:0] WINDOW_RESET  = 7'd35;
    localparam logic [1:0] UNKNOWN_COLOR = 2'd3;

    localparam logic ACT_DETECT = 1'b0;
    localparam logic ACT_EOF    = 1'b1;

    typedef logic [1:0] color_t;

    // End-of-frame request handed from the front part to the back part
    typedef struct packed {
        logic [15:0] frame;
        color_t      color;
        logic        had_det;
    } cmd_t;

    // One result item
    typedef struct packed {
        color_t      voted_color;
        color_t      frame_winner;
        logic [6:0]  history_fill;
    } result_t;

endpackage

`default_nettype wire

FILE: hdl/tcmv_fifo.sv
// Small register queue used between the parts of the block.
`default_nettype none

module tcmv_fifo
    import tcmv_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = FIFO_DEPTH
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/tcmv_front.sv
// Front part: per-frame detection accumulation and frame winner selection.
`default_nettype none

module tcmv_front
    import tcmv_pkg::*;
#(
    parameter int MAX_PER_FRAME = MAX_PER_FRAME_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic        action,
    input  wire color_t      det_color,
    input  wire logic [15:0] goodness,
    output logic             cmd_push,
    output cmd_t             cmd
);

    localparam logic [1:0] MAX_HITS = 2'(MAX_PER_FRAME);

    logic signed [17:0] sum_reg  [4];
    logic signed [17:0] sum_next [4];
    logic [1:0]         hits_reg  [4];
    logic [1:0]         hits_next [4];
    logic [1:0]         total_reg, total_next;
    logic [15:0]        frame_reg, frame_next;
    color_t             winner;

    // Scale a sum by a hit count of one or two
    function automatic logic signed [18:0] scale(input logic signed [17:0] s,
                                                 input logic [1:0] h);
        logic signed [18:0] r;
        r = (h == 2'd2) ? {s, 1'b0} : {s[17], s};
        return r;
    endfunction

    // Highest average wins; later color wins a tie, nothing wins below zero
    always_comb
    begin
        logic signed [17:0] best_sum;
        logic [1:0]         best_hits;
        best_sum  = '0;
        best_hits = 2'd1;
        winner    = UNKNOWN_COLOR;
        for (int c = 0; c < 4; c++)
        begin
            if (hits_reg[c] != 2'd0)
            begin
                if (scale(sum_reg[c], best_hits) >= scale(best_sum, hits_reg[c]))
                begin
                    best_sum  = sum_reg[c];
                    best_hits = hits_reg[c];
                    winner    = 2'(c);
                end
            end
        end
    end

    always_comb
    begin
        sum_next   = sum_reg;
        hits_next  = hits_reg;
        total_next = total_reg;
        frame_next = frame_reg;
        cmd_push   = 1'b0;
        if (accept)
        begin
            if (action == ACT_DETECT)
            begin
                if (total_reg < MAX_HITS)
                begin
                    sum_next[det_color]  = sum_reg[det_color]
                                         + {{2{goodness[15]}}, goodness};
                    hits_next[det_color] = hits_reg[det_color] + 1'b1;
                    total_next           = total_reg + 1'b1;
                end
            end
            else
            begin
                frame_next = frame_reg + 1'b1;
                cmd_push   = 1'b1;
                for (int c = 0; c < 4; c++)
                begin
                    sum_next[c]  = '0;
                    hits_next[c] = '0;
                end
                total_next = '0;
            end
        end
    end

    assign cmd.frame   = frame_reg + 1'b1;
    assign cmd.color   = winner;
    assign cmd.had_det = (total_reg != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < 4; c++)
            begin
                sum_reg[c]  <= '0;
                hits_reg[c] <= '0;
            end
            total_reg <= '0;
            frame_reg <= '0;
        end
        else
        begin
            sum_reg   <= sum_next;
            hits_reg  <= hits_next;
            total_reg <= total_next;
            frame_reg <= frame_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/tcmv_back.sv
// Back part: history ring, window eviction and majority vote.
`default_nettype none

module tcmv_back
    import tcmv_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [6:0] window_frames,
    input  wire logic       cmd_valid,
    input  wire cmd_t       cmd,
    output logic            cmd_pop,
    input  wire logic       out_full,
    output logic            out_push,
    output result_t         result
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam int SW = CW + 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WAIT  = 2'd1;
    localparam logic [1:0] ST_CHECK = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] tally_reg  [4];
    logic [CW-1:0] tally_next [4];
    logic [15:0]   newest_reg, newest_next;
    color_t        frame_winner_reg, frame_winner_next;

    logic [17:0]   hist_mem [HISTORY_DEPTH];
    logic [17:0]   rd_reg;
    logic          mem_we;
    logic [AW-1:0] waddr;
    logic [SW-1:0] tail_sum;
    logic [AW-1:0] head_inc;
    logic [15:0]   diff;
    logic          is_full;
    color_t        head_color;
    color_t        voted;

    assign head_color = rd_reg[1:0];
    assign is_full    = (count_reg == CW'(HISTORY_DEPTH));
    assign tail_sum   = SW'(head_reg) + SW'(count_reg);
    assign waddr      = (tail_sum >= SW'(HISTORY_DEPTH))
                      ? AW'(tail_sum - SW'(HISTORY_DEPTH)) : AW'(tail_sum);
    assign head_inc   = (head_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign diff       = newest_reg - rd_reg[17:2];

    // Most frequent color; earlier color wins a tie
    always_comb
    begin
        logic [CW-1:0] top_count;
        top_count = '0;
        voted     = UNKNOWN_COLOR;
        for (int c = 0; c < 4; c++)
        begin
            if (tally_reg[c] > top_count)
            begin
                top_count = tally_reg[c];
                voted     = 2'(c);
            end
        end
    end

    assign result.voted_color  = voted;
    assign result.frame_winner = frame_winner_reg;
    assign result.history_fill = 7'(count_reg);

    always_comb
    begin
        state_next        = state_reg;
        head_next         = head_reg;
        count_next        = count_reg;
        tally_next        = tally_reg;
        newest_next       = newest_reg;
        frame_winner_next = frame_winner_reg;
        cmd_pop           = 1'b0;
        out_push          = 1'b0;
        mem_we            = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && !out_full)
                begin
                    cmd_pop           = 1'b1;
                    frame_winner_next = cmd.color;
                    if (cmd.had_det)
                    begin
                        mem_we      = 1'b1;
                        newest_next = cmd.frame;
                        if (is_full)
                        begin
                            // drop the oldest; its slot takes the new entry
                            if (tally_reg[head_color] != '0)
                            begin
                                tally_next[head_color] = tally_reg[head_color] - 1'b1;
                            end
                            head_next = head_inc;
                        end
                        else
                        begin
                            count_next = count_reg + 1'b1;
                        end
                        tally_next[cmd.color] = tally_next[cmd.color] + 1'b1;
                    end
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (count_reg != '0 && diff >= {9'b0, window_frames})
                begin
                    if (tally_reg[head_color] != '0)
                    begin
                        tally_next[head_color] = tally_reg[head_color] - 1'b1;
                    end
                    head_next  = head_inc;
                    count_next = count_reg - 1'b1;
                    state_next = ST_WAIT;
                end
                else
                begin
                    out_push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            head_reg         <= '0;
            count_reg        <= '0;
            for (int c = 0; c < 4; c++)
            begin
                tally_reg[c] <= '0;
            end
            newest_reg       <= '0;
            frame_winner_reg <= UNKNOWN_COLOR;
        end
        else
        begin
            state_reg        <= state_next;
            head_reg         <= head_next;
            count_reg        <= count_next;
            tally_reg        <= tally_next;
            newest_reg       <= newest_next;
            frame_winner_reg <= frame_winner_next;
        end
    end

    // History memory: one write port, head entry read into a register
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            hist_mem[waddr] <= {cmd.frame, cmd.color};
        end
        rd_reg <= hist_mem[head_reg];
    end

endmodule

`default_nettype wire

FILE: hdl/temporal_color_majority_vote.sv
// Top level of the temporal color majority vote block.
// Usage:
//   Requests enter on push/full: action 0 carries one detection (det_color,
//   goodness) of the current frame, action 1 closes the frame. Only the first
//   MAX_PER_FRAME detections of a frame count.
//   Each end-of-frame request yields one result on empty/pop: voted_color is
//   the most frequent color of the history, frame_winner the winner of the
//   frame (highest average goodness), history_fill the number of history
//   entries. Detections yield no result.
//   An end-of-frame request is classified by the front part as it is accepted.
//   The back part then steps through idle, wait and check, with a further wait
//   and check per evicted history entry, for the registered read of the history
//   memory at the head of the ring; only after the result does it take another.
//   A two-entry request queue decouples front and back; a two-entry result
//   queue holds finished results. When the receiver stalls, results collect,
//   then the back part holds, then full rises and input requests hold.
//   Reset empties the history and both queues and loads window_frames with 35.
//   cfg_we/cfg_wdata write window_frames; write only while the block is idle.
`default_nettype none

module temporal_color_majority_vote
    import tcmv_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    parameter int MAX_PER_FRAME = MAX_PER_FRAME_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire logic        action,
    input  wire logic [1:0]  det_color,
    input  wire logic [15:0] goodness,
    output logic             full,
    input  wire logic        pop,
    output logic             empty,
    output logic [1:0]       voted_color,
    output logic [1:0]       frame_winner,
    output logic [6:0]       history_fill,
    input  wire logic        cfg_we,
    input  wire logic [6:0]  cfg_wdata
);

    logic [6:0] window_reg;
    logic       accept;
    logic       cmd_push, cmd_pop, cmd_empty;
    cmd_t       cmd_in, cmd_out;
    logic       out_push, out_full;
    result_t    res_in, res_out;

    // Window register, written any time the enable is high
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
        end
        else if (cfg_we)
        begin
            window_reg <= cfg_wdata;
        end
    end

    // Full tracks the request queue; detections also hold while it is full
    assign accept = push && !full;

    tcmv_front #(
        .MAX_PER_FRAME (MAX_PER_FRAME)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .action      (action),
        .det_color   (det_color),
        .goodness    (goodness),
        .cmd_push    (cmd_push),
        .cmd         (cmd_in)
    );

    tcmv_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (FIFO_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd_in),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (cmd_out),
        .empty (cmd_empty)
    );

    tcmv_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .window_frames (window_reg),
        .cmd_valid     (!cmd_empty),
        .cmd           (cmd_out),
        .cmd_pop       (cmd_pop),
        .out_full      (out_full),
        .out_push      (out_push),
        .result        (res_in)
    );

    tcmv_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (FIFO_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (res_in),
        .full  (out_full),
        .pop   (pop),
        .rdata (res_out),
        .empty (empty)
    );

    assign voted_color  = res_out.voted_color;
    assign frame_winner = res_out.frame_winner;
    assign history_fill = res_out.history_fill;

endmodule

`default_nettype wire
